/* sv/apg_pkg.sv */
// package for the arc point generator: quarter-wave sine table, trig helpers
// and the job record that travels from the walk front end to the point back end
// no dependencies
`default_nettype none

package apg_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  localparam logic [9:0] QUARTER_TURN = 10'd256;

  localparam logic [7:0] QUARTER_SINE [256] = '{
    8'd0, 8'd2, 8'd3, 8'd5, 8'd6, 8'd8, 8'd9, 8'd11, 8'd13, 8'd14, 8'd16, 8'd17,
    8'd19, 8'd20, 8'd22, 8'd24, 8'd25, 8'd27, 8'd28, 8'd30, 8'd31, 8'd33, 8'd34,
    8'd36, 8'd38, 8'd39, 8'd41, 8'd42, 8'd44, 8'd45, 8'd47, 8'd48, 8'd50, 8'd51,
    8'd53, 8'd55, 8'd56, 8'd58, 8'd59, 8'd61, 8'd62, 8'd64, 8'd65, 8'd67, 8'd68,
    8'd70, 8'd71, 8'd73, 8'd74, 8'd76, 8'd77, 8'd79, 8'd80, 8'd82, 8'd83, 8'd85,
    8'd86, 8'd88, 8'd89, 8'd91, 8'd92, 8'd94, 8'd95, 8'd96, 8'd98, 8'd99, 8'd101,
    8'd102, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109, 8'd111, 8'd112, 8'd114, 8'd115,
    8'd116, 8'd118, 8'd119, 8'd121, 8'd122, 8'd123, 8'd125, 8'd126, 8'd127, 8'd129,
    8'd130, 8'd132, 8'd133, 8'd134, 8'd136, 8'd137, 8'd138, 8'd140, 8'd141, 8'd142,
    8'd143, 8'd145, 8'd146, 8'd147, 8'd149, 8'd150, 8'd151, 8'd152, 8'd154, 8'd155,
    8'd156, 8'd157, 8'd159, 8'd160, 8'd161, 8'd162, 8'd164, 8'd165, 8'd166, 8'd167,
    8'd168, 8'd169, 8'd171, 8'd172, 8'd173, 8'd174, 8'd175, 8'd176, 8'd178, 8'd179,
    8'd180, 8'd181, 8'd182, 8'd183, 8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd190,
    8'd191, 8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199, 8'd200,
    8'd201, 8'd202, 8'd203, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208, 8'd209,
    8'd210, 8'd211, 8'd212, 8'd213, 8'd213, 8'd214, 8'd215, 8'd216, 8'd217, 8'd218,
    8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd222, 8'd223, 8'd224, 8'd225, 8'd225,
    8'd226, 8'd227, 8'd228, 8'd228, 8'd229, 8'd230, 8'd230, 8'd231, 8'd232, 8'd232,
    8'd233, 8'd234, 8'd234, 8'd235, 8'd235, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238,
    8'd239, 8'd239, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd243,
    8'd244, 8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd247, 8'd247, 8'd248,
    8'd248, 8'd248, 8'd249, 8'd249, 8'd249, 8'd250, 8'd250, 8'd250, 8'd251, 8'd251,
    8'd251, 8'd251, 8'd252, 8'd252, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd253,
    8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  typedef struct packed {
    logic [9:0]         angle;
    logic signed [15:0] radius;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic               last;
  } job_t;

  // 1024 steps per turn, only the low ten angle bits matter
  function automatic logic signed [8:0] sine_of(input logic [9:0] ang);
    logic [1:0] quad;
    logic [7:0] low;
    logic [7:0] mag;
    begin
      quad = ang[9:8];
      low  = ang[7:0];
      if (quad == QUAD_FIRST || quad == QUAD_THIRD) begin
        mag = QUARTER_SINE[low];
      end else begin
        mag = QUARTER_SINE[~low];
      end
      if (quad == QUAD_THIRD || quad == QUAD_FOURTH) begin
        sine_of = -$signed({1'b0, mag});
      end else begin
        sine_of = $signed({1'b0, mag});
      end
    end
  endfunction

  function automatic logic signed [8:0] cosine_of(input logic [9:0] ang);
    logic [9:0] shifted;
    begin
      shifted   = ang + QUARTER_TURN;
      cosine_of = sine_of(shifted);
    end
  endfunction

endpackage

`default_nettype wire

/* sv/arc_point_generator.sv */
// top level of the arc point generator: walk front end, job queue, point back end
// uses apg_pkg, apg_front, apg_queue, apg_back
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall  mode, center_x .. curve_phase
//   point     out        out_valid / out_stall point_x, point_y, last
//
// one request per cycle sustained while in_stall is low; a tick's point is queued on the edge
// where it is taken, then passes the lookup, multiply and scale-and-add registers in turn
// in_stall is high only while the four-entry job queue is full
// out_stall holds the back end stage by stage; the queue absorbs the difference
// rst is synchronous: clears the walk, the queue and all valid flags, no arc loaded
`default_nettype none

module arc_point_generator import apg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [15:0] center_x,
  input  wire logic [15:0] center_y,
  input  wire logic [15:0] radius,
  input  wire logic [15:0] start_angle,
  input  wire logic [15:0] finish_angle,
  input  wire logic [7:0]  step,
  input  wire logic        curve_enable,
  input  wire logic [15:0] curve_phase,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      point_x,
  output logic [15:0]      point_y,
  output logic             last
);

  logic accept;
  logic push;
  job_t push_job;
  logic q_full;
  logic head_valid;
  job_t head_job;
  logic back_ready;
  logic pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign pop      = head_valid && back_ready;

  apg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (mode),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .start_angle  (start_angle),
    .finish_angle (finish_angle),
    .step         (step),
    .curve_enable (curve_enable),
    .curve_phase  (curve_phase),
    .push         (push),
    .job          (push_job)
  );

  apg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  apg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_ready (back_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .last      (last)
  );

endmodule

`default_nettype wire

/* sv/apg_front.sv */
// front end of the arc point generator: takes load and tick requests, keeps the
// walk state and pushes one job per point into the queue; uses apg_pkg
`default_nettype none

module apg_front import apg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic        mode,
  input  wire logic [15:0] center_x,
  input  wire logic [15:0] center_y,
  input  wire logic [15:0] radius,
  input  wire logic [15:0] start_angle,
  input  wire logic [15:0] finish_angle,
  input  wire logic [7:0]  step,
  input  wire logic        curve_enable,
  input  wire logic [15:0] curve_phase,
  output logic             push,
  output job_t             job
);

  logic        busy;
  logic [15:0] walk_angle;
  logic [15:0] end_angle;
  logic        walk_down;
  logic [7:0]  step_size;
  logic [15:0] centre_x_reg;
  logic [15:0] centre_y_reg;
  logic [15:0] base_radius;
  logic        curve_on;
  logic [15:0] curve_offset;

  logic [9:0]         mod_angle;
  logic signed [8:0]  mod_cos;
  logic [15:0]        radius_now;
  logic [16:0]        angle_up;
  logic [15:0]        angle_dn;
  logic               final_pt;

  assign push = accept && mode && busy;

  // curve mode: radius plus cos(16 * angle + phase)
  always_comb begin
    mod_angle  = {walk_angle[5:0], 4'b0000} + curve_offset[9:0];
    mod_cos    = cosine_of(mod_angle);
    radius_now = curve_on ? base_radius + {{7{mod_cos[8]}}, mod_cos} : base_radius;
  end

  always_comb begin
    angle_up = {1'b0, walk_angle} + {9'd0, step_size};
    angle_dn = walk_angle - {8'd0, step_size};
    if (step_size == 8'd0) begin
      final_pt = 1'b1;
    end else if (!walk_down) begin
      final_pt = angle_up[16] || (angle_up[15:0] > end_angle);
    end else begin
      final_pt = (walk_angle < {8'd0, step_size}) || (angle_dn < end_angle);
    end
  end

  always_comb begin
    job.angle  = walk_angle[9:0];
    job.radius = $signed(radius_now);
    job.cx     = centre_x_reg;
    job.cy     = centre_y_reg;
    job.last   = final_pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      if (!mode) begin
        busy <= 1'b1;
      end else if (busy && final_pt) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !mode) begin
      centre_x_reg <= center_x;
      centre_y_reg <= center_y;
      base_radius  <= radius;
      walk_angle   <= start_angle;
      end_angle    <= finish_angle;
      step_size    <= step;
      curve_on     <= curve_enable;
      curve_offset <= curve_phase;
      walk_down    <= !(start_angle < finish_angle);
    end else if (push && !final_pt) begin
      walk_angle <= walk_down ? angle_dn : angle_up[15:0];
    end
  end

endmodule

`default_nettype wire

/* sv/apg_queue.sv */
// short job queue between the walk front end and the point back end
// uses apg_pkg for the job record and the depth
`default_nettype none

module apg_queue import apg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  output logic      head_valid,
  input  wire logic pop,
  output job_t      head_job
);

  job_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;

  assign full       = (count == QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/apg_back.sv */
// back end of the arc point generator: table lookup, multiply, scale and add
// in three registered stages with per-stage flow control; uses apg_pkg
`default_nettype none

module apg_back import apg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  job_valid,
  input  wire job_t  job,
  output logic       job_ready,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [15:0] point_x,
  output logic [15:0] point_y,
  output logic        last
);

  // stage 1: trig values
  logic               v1;
  logic signed [8:0]  cos1;
  logic signed [8:0]  sin1;
  logic signed [15:0] rad1;
  logic [15:0]        cx1;
  logic [15:0]        cy1;
  logic               last1;

  // stage 2: products
  logic               v2;
  logic signed [24:0] px2;
  logic signed [24:0] py2;
  logic [15:0]        cx2;
  logic [15:0]        cy2;
  logic               last2;

  logic ready1;
  logic ready2;
  logic ready3;

  logic signed [24:0] px_adj;
  logic signed [24:0] py_adj;

  assign ready3    = !out_valid || !out_stall;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign job_ready = ready1;

  // divide by 256 truncating toward zero
  always_comb begin
    px_adj = px2 + (px2[24] ? 25'sd255 : 25'sd0);
    py_adj = py2 + (py2[24] ? 25'sd255 : 25'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= job_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && job_valid) begin
      cos1  <= cosine_of(job.angle);
      sin1  <= sine_of(job.angle);
      rad1  <= job.radius;
      cx1   <= job.cx;
      cy1   <= job.cy;
      last1 <= job.last;
    end
    if (ready2 && v1) begin
      px2   <= cos1 * rad1;
      py2   <= sin1 * rad1;
      cx2   <= cx1;
      cy2   <= cy1;
      last2 <= last1;
    end
    if (ready3 && v2) begin
      point_x <= cx2 + px_adj[23:8];
      point_y <= cy2 + py_adj[23:8];
      last    <= last2;
    end
  end

endmodule

`default_nettype wire

/* sv/apg_checker.sv */
// port-level checks for the arc point generator, bound to the top level
// depends on arc_point_generator only through its ports
`default_nettype none

module apg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] point_x,
  input wire logic [15:0] point_y,
  input wire logic        last
);

  // a held point keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("point dropped while stalled");

  // a held point keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(point_x) && $stable(point_y) && $stable(last))
    else $error("point payload changed while stalled");

  // reset empties the back end
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("point valid after reset");

  // reset empties the queue so requests are taken right away
  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("request stall after reset");

endmodule

bind arc_point_generator apg_checker u_apg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .point_x   (point_x),
  .point_y   (point_y),
  .last      (last)
);

`default_nettype wire

/* tb/arc_point_generator_test.sv */
// self-checking testbench for arc_point_generator: a table of directed requests, then
// random arcs, checked against hand-set points or a bit-true point predictor in this module
// depends on apg_pkg (sine table, quarter turn) and the arc_point_generator rtl
module arc_point_generator_test;
  import apg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic LOAD = 1'b0;
  localparam logic TICK = 1'b1;
  localparam logic BY_HAND = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam int SCRIPT_ROWS = 24;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES = 160;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic        mode;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] rad;
    logic [15:0] start;
    logic [15:0] fin;
    logic [7:0]  stp;
    logic        curve;
    logic [15:0] phase;
  } arc_req_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        is_last;
  } arc_point_t;

  typedef struct packed {
    arc_req_t   req;
    logic       typed;
    logic       has_pt;
    arc_point_t pt;
  } script_row_t;

  localparam arc_point_t NO_POINT = '{16'h0, 16'h0, 1'b0};
  localparam arc_req_t TICK_REQ = '{TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 1'b0, 16'h0};

  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // tick with no arc loaded
    '{TICK_REQ, BY_HAND, 1'b0, NO_POINT},
    // zero radius, zero step: the center alone, marked last
    '{'{LOAD, 16'd100, 16'hFFCE, 16'h0, 16'h0, 16'h0, 8'd0, 1'b0, 16'h0},
      BY_HAND, 1'b0, NO_POINT},
    '{TICK_REQ, BY_HAND, 1'b1, '{16'd100, 16'hFFCE, 1'b1}},
    '{TICK_REQ, BY_HAND, 1'b0, NO_POINT},
    // angle 0: cosine is the table peak, sine is zero
    '{'{LOAD, 16'h0, 16'h0, 16'd256, 16'h0, 16'h0, 8'd0, 1'b0, 16'h0},
      BY_HAND, 1'b0, NO_POINT},
    '{TICK_REQ, BY_HAND, 1'b1, '{16'd255, 16'h0, 1'b1}},
    // largest center plus largest radius wraps
    '{'{LOAD, 16'h7FFF, 16'h0, 16'h7FFF, 16'h0, 16'h0, 8'd0, 1'b0, 16'h0},
      BY_HAND, 1'b0, NO_POINT},
    '{TICK_REQ, BY_HAND, 1'b1, '{16'hFF7E, 16'h0, 1'b1}},
    // upward walk, largest step, ends on passing the finish
    '{'{LOAD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0, 16'd600, 8'd255, 1'b0, 16'h0},
      PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    // downward walk from the top angle in curve mode
    '{'{LOAD, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0, 8'd200, 1'b1, 16'hFFFF},
      PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    // new arc replaces the running one; upward counter wrap ends it at once
    '{'{LOAD, 16'h1234, 16'hEDCC, 16'd1000, 16'd65500, 16'hFFFF, 8'd255, 1'b0, 16'h0},
      PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    // downward counter wrap
    '{'{LOAD, 16'h0, 16'h0, 16'hC000, 16'd100, 16'h0, 8'd255, 1'b1, 16'h8000},
      PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    // start equal to finish walks down and stops after one point
    '{'{LOAD, 16'hFFFF, 16'h0001, 16'h8000, 16'd512, 16'd512, 8'd1, 1'b1, 16'h0},
      PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    '{'{LOAD, 16'h0010, 16'hFFF0, 16'h4000, 16'h0, 16'hFFFF, 8'd128, 1'b1, 16'h1234},
      PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT},
    '{TICK_REQ, PREDICTED, 1'b0, NO_POINT}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [15:0] center_x = '0;
  logic [15:0] center_y = '0;
  logic [15:0] radius = '0;
  logic [15:0] start_angle = '0;
  logic [15:0] finish_angle = '0;
  logic [7:0]  step = '0;
  logic        curve_enable = 1'b0;
  logic [15:0] curve_phase = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic        last;

  arc_point_generator uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .center_x(center_x), .center_y(center_y), .radius(radius),
    .start_angle(start_angle), .finish_angle(finish_angle), .step(step),
    .curve_enable(curve_enable), .curve_phase(curve_phase), .out_valid(out_valid),
    .out_stall(out_stall), .point_x(point_x), .point_y(point_y), .last(last)
  );

  // predicted arc state
  logic        arc_active = 1'b0;
  logic [15:0] cur_angle = '0;
  logic [15:0] stop_angle = '0;
  logic        going_down = 1'b0;
  logic [7:0]  angle_step = '0;
  logic [15:0] hold_cx = '0;
  logic [15:0] hold_cy = '0;
  logic [15:0] hold_radius = '0;
  logic        wobble_on = 1'b0;
  logic [15:0] wobble_phase = '0;

  arc_point_t pending_points [$];
  int mismatches = 0;
  int issued = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // bit 8 mirrors the quarter table, bit 9 negates
  function automatic int lut_sine(input logic [9:0] ang);
    int mag;
    mag = ang[8] ? QUARTER_SINE[8'd255 - ang[7:0]] : QUARTER_SINE[ang[7:0]];
    return ang[9] ? -mag : mag;
  endfunction

  function automatic int lut_cosine(input logic [9:0] ang);
    logic [9:0] turned;
    turned = ang + QUARTER_TURN;
    return lut_sine(turned);
  endfunction

  // signed division truncates toward zero, sum wraps to 16 bits
  function automatic logic [15:0] place(input logic [15:0] origin, input int trig,
                                        input int rad);
    int q;
    q = (trig * rad) / 256;
    return origin + q[15:0];
  endfunction

  function automatic bit advance_arc(input arc_req_t r, output arc_point_t p);
    int rad_eff, a, s, nx, stop;
    logic [15:0] mod_ang, wrapped;
    p = NO_POINT;
    if (r.mode == LOAD) begin
      hold_cx = r.cx;
      hold_cy = r.cy;
      hold_radius = r.rad;
      cur_angle = r.start;
      stop_angle = r.fin;
      angle_step = r.stp;
      wobble_on = r.curve;
      wobble_phase = r.phase;
      going_down = !(r.start < r.fin);
      arc_active = 1'b1;
      return 1'b0;
    end
    if (!arc_active) return 1'b0;
    rad_eff = $signed(hold_radius);
    if (wobble_on) begin
      mod_ang = {cur_angle[11:0], 4'b0000} + wobble_phase;
      wrapped = 16'(rad_eff + lut_cosine(mod_ang[9:0]));
      rad_eff = $signed(wrapped);
    end
    p.x = place(hold_cx, lut_cosine(cur_angle[9:0]), rad_eff);
    p.y = place(hold_cy, lut_sine(cur_angle[9:0]), rad_eff);
    a = cur_angle;
    s = angle_step;
    stop = stop_angle;
    nx = going_down ? a - s : a + s;
    if (s == 0) p.is_last = 1'b1;
    else if (!going_down) p.is_last = (nx > 65535) || (nx > stop);
    else p.is_last = (nx < 0) || (nx < stop);
    if (p.is_last) arc_active = 1'b0;
    else cur_angle = nx[15:0];
    return 1'b1;
  endfunction

  function automatic arc_req_t scramble();
    arc_req_t q;
    q.mode = 1'($urandom);
    q.cx = 16'($urandom);
    q.cy = 16'($urandom);
    q.rad = 16'($urandom);
    q.start = 16'($urandom);
    q.fin = 16'($urandom);
    q.stp = 8'($urandom);
    q.curve = 1'($urandom);
    q.phase = 16'($urandom);
    return q;
  endfunction

  // returns at the edge where the request is taken
  task automatic offer(input arc_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= r.mode;
    center_x <= r.cx;
    center_y <= r.cy;
    radius <= r.rad;
    start_angle <= r.start;
    finish_angle <= r.fin;
    step <= r.stp;
    curve_enable <= r.curve;
    curve_phase <= r.phase;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue(input arc_req_t r, output arc_point_t p);
    bit got;
    offer(r);
    got = advance_arc(r, p);
    if (got) pending_points.push_back(p);
    else p = NO_POINT;
    if (r.mode == LOAD || got) issued++;
  endtask

  initial begin : stimulus
    arc_req_t r;
    arc_point_t pt;
    bit got;
    int pick, span, fin_i, cut, extra;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      offer(SCRIPT[i].req);
      got = advance_arc(SCRIPT[i].req, pt);
      if (SCRIPT[i].typed == BY_HAND) begin
        if (SCRIPT[i].has_pt) pending_points.push_back(SCRIPT[i].pt);
      end else if (got) begin
        pending_points.push_back(pt);
      end
    end

    while (issued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        issue(scramble(), pt);
      end else begin
        r = scramble();
        r.mode = LOAD;
        pick = $urandom_range(0, 9);
        if (pick == 0) r.stp = 8'd0;
        else if (pick == 1) r.stp = 8'd255;
        else r.stp = 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 9);
        if (pick == 0) r.start = 16'($urandom_range(0, 300));
        else if (pick == 1) r.start = 16'($urandom_range(65235, 65535));
        pick = $urandom_range(0, 9);
        if (pick == 0) r.rad = 16'h7FFF;
        else if (pick == 1) r.rad = 16'h8000;
        span = int'(r.stp) * int'($urandom_range(0, 12));
        fin_i = $urandom_range(0, 1) ? int'(r.start) + span : int'(r.start) - span;
        if (fin_i > 65535) fin_i = 65535;
        if (fin_i < 0) fin_i = 0;
        if ($urandom_range(0, 9) != 0) r.fin = fin_i[15:0];
        issue(r, pt);
        // now and then the arc is cut short by the next load
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 40;
        for (int t = 0; t < cut; t++) begin
          r = scramble();
          r.mode = TICK;
          issue(r, pt);
          if (pt.is_last) break;
        end
        extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        repeat (extra) begin
          r = scramble();
          r.mode = TICK;
          issue(r, pt);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("arc_point_generator test passed");
    end else begin
      $display("arc_point_generator test failed");
    end
    $finish;
  end

  // receiver: quiet, light and heavy stall stretches, plus long hold-offs that fill the block
  initial begin : receiver
    int seg, pct;
    seg = 0;
    pct = 0;
    while (rst) @(posedge clk);
    forever begin
      if (seg % 5 == 2) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 30;
          default: pct = 75;
        endcase
        repeat ($urandom_range(20, 120)) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  always @(posedge clk) begin : point_check
    arc_point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("point with no request pending: x=%h y=%h last=%b", point_x, point_y, last);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) begin
          $error("point_x expected %h got %h", want.x, point_x);
          mismatches++;
        end
        if (point_y !== want.y) begin
          $error("point_y expected %h got %h", want.y, point_y);
          mismatches++;
        end
        if (last !== want.is_last) begin
          $error("last expected %b got %b", want.is_last, last);
          mismatches++;
        end
      end
    end
  end

  // nothing taken on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("arc_point_generator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* sim.f */
sv/apg_pkg.sv
sv/apg_front.sv
sv/apg_queue.sv
sv/apg_back.sv
sv/arc_point_generator.sv
sv/apg_checker.sv
tb/arc_point_generator_test.sv
